// ===== src/i2c_master_bit_sequencer_unit_defines.svh =====
// ---------------------------------------------------------------------------
// i2c master bit sequencer assertion macros
// shared checker shorthands for the bit sequencer rtl
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_SEQUENCER_UNIT_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, checked at every rising edge out of reset
`define IBS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ibs_pkg.sv =====
// ---------------------------------------------------------------------------
// ibs_pkg
// types, opcodes and microcode layout for the i2c bit sequencer
// ---------------------------------------------------------------------------
package ibs_pkg;

  localparam int StepW = 5;
  localparam int BitW  = 3;

  typedef logic [StepW-1:0] step_t;
  typedef logic [BitW-1:0]  bit_idx_t;

  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_STOP     = 3'd1,
    OP_WRITE    = 3'd2,
    OP_READ     = 3'd3,
    OP_SEND_ACK = 3'd4,
    OP_RECV_ACK = 3'd5
  } op_t;

  // program entry points
  localparam step_t STEP_START    = 5'd0;
  localparam step_t STEP_STOP     = 5'd4;
  localparam step_t STEP_WRITE    = 5'd7;
  localparam step_t STEP_READ     = 5'd10;
  localparam step_t STEP_READ_BIT = 5'd11;
  localparam step_t STEP_SEND_ACK = 5'd13;
  localparam step_t STEP_RECV_ACK = 5'd16;

  localparam bit_idx_t LAST_BIT = 3'd7;

  typedef enum logic [1:0] {
    SCL_KEEP = 2'd0,
    SCL_LO   = 2'd1,
    SCL_HI   = 2'd2
  } scl_sel_t;

  typedef enum logic [1:0] {
    SDA_HI  = 2'd0,
    SDA_LO  = 2'd1,
    SDA_TX  = 2'd2,
    SDA_ACK = 2'd3
  } sda_sel_t;

  typedef enum logic [1:0] {
    FLOW_NEXT = 2'd0,
    FLOW_LOOP = 2'd1,
    FLOW_END  = 2'd2
  } flow_t;

  typedef struct packed {
    scl_sel_t scl_sel;
    sda_sel_t sda_sel;
    logic     sample;
    logic     rx_sel;
    logic     ack_sel;
    flow_t    flow;
    step_t    loop_to;
  } ctl_word_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       ack_out;
    logic [7:0] line_bits;
    logic       ack_in;
  } cmd_t;

  typedef struct packed {
    logic       issue;
    logic       last;
    bit_idx_t   bit_idx;
  } seq_stat_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       sample_now;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       last;
  } phase_t;

  typedef struct packed {
    logic  valid;
    step_t step;
  } entry_t;

  function automatic entry_t entry_of(logic [2:0] opcode);
    entry_t e;
    e.valid = 1'b1;
    case (opcode)
      OP_START:    e.step = STEP_START;
      OP_STOP:     e.step = STEP_STOP;
      OP_WRITE:    e.step = STEP_WRITE;
      OP_READ:     e.step = STEP_READ;
      OP_SEND_ACK: e.step = STEP_SEND_ACK;
      OP_RECV_ACK: e.step = STEP_RECV_ACK;
      default: begin
        e.valid = 1'b0;
        e.step  = STEP_START;
      end
    endcase
    return e;
  endfunction

endpackage

// ===== src/ibs_ucode_rom.sv =====
// ---------------------------------------------------------------------------
// ibs_ucode_rom
// control store: one control word per sequencer step
// ---------------------------------------------------------------------------
module ibs_ucode_rom (
  input  ibs_pkg::step_t     step,
  output ibs_pkg::ctl_word_t ctl
);
  import ibs_pkg::*;

  function automatic ctl_word_t cw(scl_sel_t c, sda_sel_t d, logic smp, logic rx,
                                   logic ack, flow_t f, step_t to);
    ctl_word_t w;
    w.scl_sel = c;
    w.sda_sel = d;
    w.sample  = smp;
    w.rx_sel  = rx;
    w.ack_sel = ack;
    w.flow    = f;
    w.loop_to = to;
    return w;
  endfunction

  always_comb begin
    case (step)
      // start
      5'd0:  ctl = cw(SCL_KEEP, SDA_HI,  1'b0, 1'b0, 1'b0, FLOW_NEXT, STEP_START);
      5'd1:  ctl = cw(SCL_HI,   SDA_HI,  1'b0, 1'b0, 1'b0, FLOW_NEXT, STEP_START);
      5'd2:  ctl = cw(SCL_HI,   SDA_LO,  1'b0, 1'b0, 1'b0, FLOW_NEXT, STEP_START);
      5'd3:  ctl = cw(SCL_LO,   SDA_LO,  1'b0, 1'b0, 1'b0, FLOW_END,  STEP_START);
      // stop
      5'd4:  ctl = cw(SCL_KEEP, SDA_LO,  1'b0, 1'b0, 1'b0, FLOW_NEXT, STEP_START);
      5'd5:  ctl = cw(SCL_HI,   SDA_LO,  1'b0, 1'b0, 1'b0, FLOW_NEXT, STEP_START);
      5'd6:  ctl = cw(SCL_HI,   SDA_HI,  1'b0, 1'b0, 1'b0, FLOW_END,  STEP_START);
      // write byte, three phases per bit
      5'd7:  ctl = cw(SCL_KEEP, SDA_TX,  1'b0, 1'b0, 1'b0, FLOW_NEXT, STEP_START);
      5'd8:  ctl = cw(SCL_HI,   SDA_TX,  1'b0, 1'b0, 1'b0, FLOW_NEXT, STEP_START);
      5'd9:  ctl = cw(SCL_LO,   SDA_TX,  1'b0, 1'b0, 1'b0, FLOW_LOOP, STEP_WRITE);
      // read byte, release then two phases per bit
      5'd10: ctl = cw(SCL_KEEP, SDA_HI,  1'b0, 1'b0, 1'b0, FLOW_NEXT, STEP_START);
      5'd11: ctl = cw(SCL_HI,   SDA_HI,  1'b1, 1'b0, 1'b0, FLOW_NEXT, STEP_START);
      5'd12: ctl = cw(SCL_LO,   SDA_HI,  1'b0, 1'b1, 1'b0, FLOW_LOOP, STEP_READ_BIT);
      // send ack
      5'd13: ctl = cw(SCL_KEEP, SDA_ACK, 1'b0, 1'b0, 1'b0, FLOW_NEXT, STEP_START);
      5'd14: ctl = cw(SCL_HI,   SDA_ACK, 1'b0, 1'b0, 1'b0, FLOW_NEXT, STEP_START);
      5'd15: ctl = cw(SCL_LO,   SDA_ACK, 1'b0, 1'b0, 1'b0, FLOW_END,  STEP_START);
      // receive ack
      5'd16: ctl = cw(SCL_KEEP, SDA_HI,  1'b0, 1'b0, 1'b0, FLOW_NEXT, STEP_START);
      5'd17: ctl = cw(SCL_HI,   SDA_HI,  1'b1, 1'b0, 1'b0, FLOW_NEXT, STEP_START);
      5'd18: ctl = cw(SCL_LO,   SDA_HI,  1'b0, 1'b0, 1'b1, FLOW_END,  STEP_START);
      default: ctl = cw(SCL_KEEP, SDA_HI, 1'b0, 1'b0, 1'b0, FLOW_END, STEP_START);
    endcase
  end

endmodule

// ===== src/ibs_sequencer.sv =====
// ---------------------------------------------------------------------------
// ibs_sequencer
// step counter, bit loop counter and busy flag
// ---------------------------------------------------------------------------
module ibs_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic [2:0]         opcode,
  input  logic               out_free,
  input  ibs_pkg::ctl_word_t ctl,
  output ibs_pkg::step_t     step,
  output logic               busy,
  output ibs_pkg::seq_stat_t stat
);
  import ibs_pkg::*;

  bit_idx_t bit_cnt;
  entry_t   entry;
  logic     issue;
  logic     done;

  assign entry = entry_of(opcode);
  assign issue = busy && out_free;
  assign done  = (ctl.flow == FLOW_END) || ((ctl.flow == FLOW_LOOP) && (bit_cnt == LAST_BIT));

  assign stat.issue   = issue;
  assign stat.last    = done;
  assign stat.bit_idx = bit_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      step    <= STEP_START;
      bit_cnt <= '0;
    end else if (load) begin
      busy    <= entry.valid;
      step    <= entry.step;
      bit_cnt <= '0;
    end else if (issue) begin
      if (done) begin
        busy <= 1'b0;
      end else if (ctl.flow == FLOW_LOOP) begin
        step    <= ctl.loop_to;
        bit_cnt <= bit_cnt + 1'b1;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

endmodule

// ===== src/ibs_datapath.sv =====
// ---------------------------------------------------------------------------
// ibs_datapath
// command hold, bus level, receive shifter and phase formation
// ---------------------------------------------------------------------------
module ibs_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  ibs_pkg::cmd_t      cmd_in,
  input  ibs_pkg::ctl_word_t ctl,
  input  ibs_pkg::seq_stat_t stat,
  output ibs_pkg::phase_t    phase
);
  import ibs_pkg::*;

  cmd_t       cmd;
  logic       scl_level;
  logic [7:0] rx_shift;
  bit_idx_t   msb_idx;

  assign msb_idx = ~stat.bit_idx;

  always_comb begin
    case (ctl.scl_sel)
      SCL_LO:  phase.scl = 1'b0;
      SCL_HI:  phase.scl = 1'b1;
      default: phase.scl = scl_level;
    endcase
    case (ctl.sda_sel)
      SDA_LO:  phase.sda = 1'b0;
      SDA_TX:  phase.sda = cmd.tx_byte[msb_idx];
      SDA_ACK: phase.sda = cmd.ack_out;
      default: phase.sda = 1'b1;
    endcase
    phase.sample_now = ctl.sample;
    phase.rx_byte    = (ctl.rx_sel && stat.last) ? rx_shift : 8'd0;
    phase.ack_seen   = ctl.ack_sel && cmd.ack_in;
    phase.last       = stat.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scl_level <= 1'b1;
    end else if (stat.issue) begin
      scl_level <= phase.scl;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd <= cmd_in;
    end
    if (stat.issue && ctl.sample) begin
      rx_shift <= {rx_shift[6:0], cmd.line_bits[msb_idx]};
    end
  end

endmodule

// ===== src/i2c_master_bit_sequencer_unit.sv =====
// first line phase of a command is registered into the output stage once that stage is free
// throughput: one phase per cycle while the sink takes them; a command's phases
//   (start 4, stop 3, write 24, read 17, acks 3) are walked by the single step counter
//   through the control store; unused opcodes are taken and dropped with no phase
// reset: scl level idle high, sequencer idle, output stage empty
// ---------------------------------------------------------------------------
// i2c_master_bit_sequencer_unit
// microcoded bit-level i2c master: each command expands into scl/sda phases
// ---------------------------------------------------------------------------
module i2c_master_bit_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  // command stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [2:0] opcode, [10:3] tx_byte, [11] ack_out, [19:12] line_bits, [20] ack_in
  input  logic [23:0] s_tdata,
  // phase stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] scl, [1] sda, [2] sample_now, [10:3] rx_byte, [11] ack_seen
  output logic [15:0] m_tdata,
  output logic        m_tlast
);
  import ibs_pkg::*;

  `include "i2c_master_bit_sequencer_unit_defines.svh"

  cmd_t      cmd_in;
  ctl_word_t ctl;
  step_t     step;
  seq_stat_t stat;
  phase_t    phase;
  phase_t    out_q;
  logic      busy;
  logic      load;
  logic      out_free;

  // unpack the command transfer
  assign cmd_in.opcode    = s_tdata[2:0];
  assign cmd_in.tx_byte   = s_tdata[10:3];
  assign cmd_in.ack_out   = s_tdata[11];
  assign cmd_in.line_bits = s_tdata[19:12];
  assign cmd_in.ack_in    = s_tdata[20];

  // a new command is taken once the previous one has issued its last phase,
  // even while that phase still waits in the output register
  assign s_tready = !busy;
  assign load     = s_tvalid && s_tready;

  // output register can take a phase when empty or being drained
  assign out_free = !m_tvalid || m_tready;

  ibs_ucode_rom u_rom (
    .step (step),
    .ctl  (ctl)
  );

  ibs_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .opcode   (cmd_in.opcode),
    .out_free (out_free),
    .ctl      (ctl),
    .step     (step),
    .busy     (busy),
    .stat     (stat)
  );

  ibs_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .cmd_in (cmd_in),
    .ctl    (ctl),
    .stat   (stat),
    .phase  (phase)
  );

  // output stage: one phase per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (stat.issue) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.issue) begin
      out_q <= phase;
    end
  end

  assign m_tdata = {4'd0, out_q.ack_seen, out_q.rx_byte, out_q.sample_now,
                    out_q.sda, out_q.scl};
  assign m_tlast = out_q.last;

  // sampling only ever happens with scl high
  `IBS_ASSERT_IMPLY(a_sample_scl_high, stat.issue && ctl.sample, phase.scl,
    "sample issued with scl low")
  // received byte or acknowledge only on the final phase of a command
  `IBS_ASSERT_IMPLY(a_rx_on_last, m_tvalid && ((m_tdata[10:3] != 8'd0) || m_tdata[11]),
    m_tlast, "receive data outside final phase")
  // sequencer goes idle right after issuing a final phase
  `IBS_ASSERT_NEXT(a_idle_after_last, stat.issue && stat.last, !busy,
    "sequencer still busy after final phase")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: i2c master bit sequencer testbench
// walks a table of commands, then random bus transactions and noise; every
// line phase that comes back is checked against an in-bench expansion of
// the command, with idling on both sides and one long hold-off of the sink
// ---------------------------------------------------------------------------
module tb_top;
  import ibs_pkg::*;

  // opcodes with no meaning, the block must drop them
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 10;
  localparam int DIR_ROWS = 21;
  localparam int ITEMS_PER_MODE = 25;

  // one row of the directed part; chk marks rows with typed-in outcomes
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx;
    logic       ack_out;
    logic [7:0] lines;
    logic       ack_in;
    logic       chk;
    logic [4:0] n_ph;
    logic [7:0] rx;
    logic       ack;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  // bus levels as the expansion sees them
  logic bus_scl;
  logic bus_sda;

  phase_t line_phase_q[$];

  int errors = 0;
  int cycle_cnt = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    // stop straight after reset, scl still high
    '{OP_STOP,     8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 5'd3,  8'h00, 1'b0},
    '{OP_START,    8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 5'd4,  8'h00, 1'b0},
    '{OP_WRITE,    8'hFF, 1'b1, 8'h00, 1'b1, 1'b1, 5'd24, 8'h00, 1'b0},
    '{OP_RECV_ACK, 8'hFF, 1'b1, 8'hFF, 1'b0, 1'b1, 5'd3,  8'h00, 1'b0},
    '{OP_WRITE,    8'h00, 1'b0, 8'hFF, 1'b0, 1'b1, 5'd24, 8'h00, 1'b0},
    '{OP_RECV_ACK, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 5'd3,  8'h00, 1'b1},
    '{OP_WRITE,    8'hA5, 1'b1, 8'h5A, 1'b1, 1'b0, 5'd0,  8'h00, 1'b0},
    '{OP_READ,     8'hFF, 1'b1, 8'h00, 1'b1, 1'b1, 5'd17, 8'h00, 1'b0},
    '{OP_SEND_ACK, 8'hFF, 1'b0, 8'hFF, 1'b1, 1'b1, 5'd3,  8'h00, 1'b0},
    '{OP_READ,     8'h00, 1'b0, 8'hFF, 1'b0, 1'b1, 5'd17, 8'hFF, 1'b0},
    '{OP_SEND_ACK, 8'h00, 1'b1, 8'h00, 1'b0, 1'b1, 5'd3,  8'h00, 1'b0},
    '{OP_READ,     8'hFF, 1'b1, 8'h5A, 1'b1, 1'b1, 5'd17, 8'h5A, 1'b0},
    '{OP_RSVD_6,   8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1, 5'd0,  8'h00, 1'b0},
    '{OP_RSVD_7,   8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 5'd0,  8'h00, 1'b0},
    '{OP_STOP,     8'h3C, 1'b1, 8'hC3, 1'b1, 1'b0, 5'd0,  8'h00, 1'b0},
    '{OP_START,    8'hC3, 1'b0, 8'h3C, 1'b1, 1'b0, 5'd0,  8'h00, 1'b0},
    '{OP_READ,     8'h18, 1'b0, 8'h81, 1'b1, 1'b0, 5'd0,  8'h00, 1'b0},
    '{OP_RECV_ACK, 8'h7E, 1'b0, 8'h7E, 1'b1, 1'b0, 5'd0,  8'h00, 1'b0},
    '{OP_STOP,     8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 5'd0,  8'h00, 1'b0},
    // write with no start in front, bus idle high
    '{OP_WRITE,    8'h3C, 1'b0, 8'h00, 1'b0, 1'b0, 5'd0,  8'h00, 1'b0},
    '{OP_STOP,     8'h00, 1'b1, 8'h00, 1'b1, 1'b0, 5'd0,  8'h00, 1'b0}
  };

  i2c_master_bit_sequencer_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endtask

  // append one line phase; the levels become the new bus state
  task automatic push_phase(input logic scl, input logic sda, input logic smp,
                            input logic [7:0] rx, input logic ack, input logic lst,
                            inout int n, inout phase_t tail);
    bus_scl = scl;
    bus_sda = sda;
    tail = '{scl: scl, sda: sda, sample_now: smp, rx_byte: rx, ack_seen: ack,
             last: lst};
    line_phase_q.push_back(tail);
    n++;
  endtask

  // expands one command into its line phases
  task automatic expand_command(input cmd_t c, output int n, output phase_t tail);
    logic [7:0] rx_acc;
    logic       b;
    n = 0;
    tail = '0;
    rx_acc = '0;
    case (c.opcode)
      OP_START: begin
        push_phase(bus_scl, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, n, tail);
        push_phase(1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, n, tail);
        push_phase(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, n, tail);
        push_phase(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, n, tail);
      end
      OP_STOP: begin
        // scl is not lowered first, the first phase keeps it
        push_phase(bus_scl, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, n, tail);
        push_phase(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, n, tail);
        push_phase(1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, n, tail);
      end
      OP_WRITE: begin
        for (int i = 7; i >= 0; i--) begin
          b = c.tx_byte[i];
          push_phase(bus_scl, b, 1'b0, 8'h00, 1'b0, 1'b0, n, tail);
          push_phase(1'b1, b, 1'b0, 8'h00, 1'b0, 1'b0, n, tail);
          push_phase(1'b0, b, 1'b0, 8'h00, 1'b0, i == 0, n, tail);
        end
      end
      OP_READ: begin
        push_phase(bus_scl, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, n, tail);
        for (int i = 7; i >= 0; i--) begin
          push_phase(1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, n, tail);
          rx_acc[i] = c.line_bits[i];
          // the byte only shows on the closing phase
          push_phase(1'b0, 1'b1, 1'b0, (i == 0) ? rx_acc : 8'h00, 1'b0, i == 0,
                     n, tail);
        end
      end
      OP_SEND_ACK: begin
        push_phase(bus_scl, c.ack_out, 1'b0, 8'h00, 1'b0, 1'b0, n, tail);
        push_phase(1'b1, c.ack_out, 1'b0, 8'h00, 1'b0, 1'b0, n, tail);
        push_phase(1'b0, c.ack_out, 1'b0, 8'h00, 1'b0, 1'b1, n, tail);
      end
      OP_RECV_ACK: begin
        push_phase(bus_scl, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, n, tail);
        push_phase(1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, n, tail);
        push_phase(1'b0, 1'b1, 1'b0, 8'h00, c.ack_in, 1'b1, n, tail);
      end
      default: ;
    endcase
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_command(input cmd_t c, output int n, output phase_t tail);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, c.ack_in, c.line_bits, c.ack_out, c.tx_byte, c.opcode};
    do @(posedge clk); while (!s_tready);
    expand_command(c, n, tail);
    @(negedge clk);
  endtask

  function automatic cmd_t rand_cmd(input logic [2:0] op);
    cmd_t c;
    c.opcode    = op;
    c.tx_byte   = 8'($urandom);
    c.ack_out   = 1'($urandom);
    c.line_bits = 8'($urandom);
    c.ack_in    = 1'($urandom);
    return c;
  endfunction

  // mostly well-formed transactions with random content, some loose commands
  task automatic run_traffic(input int n_items);
    int         sent;
    int         n;
    phase_t     tail;
    logic [2:0] op;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        send_command(rand_cmd(OP_START), n, tail);
        send_command(rand_cmd(OP_WRITE), n, tail);
        send_command(rand_cmd(OP_RECV_ACK), n, tail);
        sent += 3;
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1) == 0) begin
            send_command(rand_cmd(OP_WRITE), n, tail);
            send_command(rand_cmd(OP_RECV_ACK), n, tail);
          end else begin
            send_command(rand_cmd(OP_READ), n, tail);
            send_command(rand_cmd(OP_SEND_ACK), n, tail);
          end
          sent += 2;
        end
        // now and then the stop is left out, next start is a repeated one
        if ($urandom_range(0, 9) != 0) begin
          send_command(rand_cmd(OP_STOP), n, tail);
          sent++;
        end
      end else begin
        op = 3'($urandom_range(0, 7));
        send_command(rand_cmd(op), n, tail);
        if (op != OP_RSVD_6 && op != OP_RSVD_7) sent++;
      end
    end
  endtask

  // sink side: random stalls, plus one long hold-off when asked for
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // every phase transfer is checked against the oldest expected phase
  always @(posedge clk) begin
    phase_t got;
    phase_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{scl: m_tdata[0], sda: m_tdata[1], sample_now: m_tdata[2],
              rx_byte: m_tdata[10:3], ack_seen: m_tdata[11], last: m_tlast};
      if (line_phase_q.size() == 0) begin
        flag_error($sformatf("unexpected phase scl=%b sda=%b smp=%b rx=%h ack=%b last=%b",
                             got.scl, got.sda, got.sample_now, got.rx_byte,
                             got.ack_seen, got.last));
      end else begin
        want = line_phase_q.pop_front();
        if (got !== want) begin
          flag_error($sformatf({"phase mismatch: exp scl=%b sda=%b smp=%b rx=%h ack=%b ",
                                "last=%b, got scl=%b sda=%b smp=%b rx=%h ack=%b last=%b"},
                               want.scl, want.sda, want.sample_now, want.rx_byte,
                               want.ack_seen, want.last, got.scl, got.sda,
                               got.sample_now, got.rx_byte, got.ack_seen, got.last));
        end
      end
    end
  end

  initial begin
    cmd_t   c;
    int     n;
    phase_t tail;
    bus_scl = 1'b1;
    bus_sda = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part, quiet sender, sink mostly ready
    rx_idle_pct = 25;
    foreach (dir_tab[i]) begin
      c = '{opcode: dir_tab[i].op, tx_byte: dir_tab[i].tx, ack_out: dir_tab[i].ack_out,
            line_bits: dir_tab[i].lines, ack_in: dir_tab[i].ack_in};
      send_command(c, n, tail);
      if (dir_tab[i].chk && (n != dir_tab[i].n_ph ||
          (n > 0 && (tail.rx_byte !== dir_tab[i].rx || tail.ack_seen !== dir_tab[i].ack)))) begin
        flag_error($sformatf("row %0d: exp %0d phases rx=%h ack=%b, got %0d rx=%h ack=%b",
                             i, dir_tab[i].n_ph, dir_tab[i].rx, dir_tab[i].ack,
                             n, tail.rx_byte, tail.ack_seen));
      end
    end

    tx_idle_pct = 25;
    rx_idle_pct = 63;
    run_traffic(ITEMS_PER_MODE);

    tx_idle_pct = 63;
    rx_idle_pct = 25;
    run_traffic(ITEMS_PER_MODE);

    // no idling; the sink holds off for a long stretch so the input stalls
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    run_traffic(ITEMS_PER_MODE);
    s_tvalid <= 1'b0;

    while (line_phase_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (line_phase_q.size() != 0)
      flag_error($sformatf("%0d phases never arrived", line_phase_q.size()));
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
